### rtl/pcgd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pcgd_pkg;

	// q16.16 constants
	localparam logic [16:0] Q_ONE        = 17'd65536;
	localparam logic [20:0] Q_HALF       = 21'd32768;
	localparam logic [31:0] Q_TWO_PI     = 32'd411775;
	localparam logic [31:0] MUL_INV10    = 32'd6554;
	localparam logic [31:0] MUL_INV120   = 32'd546;
	localparam logic [31:0] US_PER_S     = 32'd1000000;
	localparam logic [31:0] US_HALF      = 32'd500000;
	localparam logic [31:0] EXP_CUTOFF   = 32'(23 * 65536);
	localparam logic [3:0]  MAX_HALVINGS = 4'd10;
	localparam logic [31:0] SAT_MAX      = 32'h7fff_ffff;
	localparam logic [63:0] NYQ_LIM      = 64'd500000 * 64'd65536;

	// reciprocal of one million, 2^51 / 10^6 truncated
	localparam logic [31:0] RCP_1E6      = 32'd2251799813;

	// serial divider size
	localparam int DIV_W  = 52;
	localparam int DIV_CW = $clog2(DIV_W + 1);
	localparam logic [DIV_W-1:0] DIV_LIM = 52'd2147483647 * 52'd1000000;

	// result status codes
	localparam logic [1:0] STS_OK      = 2'd0;
	localparam logic [1:0] STS_INVALID = 2'd1;
	localparam logic [1:0] STS_RANGE   = 2'd2;

	// datapath micro-operations
	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_CHK,
		OP_OMEGA,
		OP_NYQ,
		OP_ROL,
		OP_LIMQ,
		OP_PPLO,
		OP_PPHI,
		OP_RCP,
		OP_QEST,
		OP_QFIX,
		OP_EXP0,
		OP_HALVE,
		OP_PX2,
		OP_PX3,
		OP_PT2,
		OP_PT3,
		OP_PSUM,
		OP_PDIV,
		OP_PRES,
		OP_SQ,
		OP_SQW,
		OP_EXPEND,
		OP_ARGBDIV,
		OP_POLES,
		OP_RB,
		OP_KPDIV,
		OP_KP,
		OP_KI
	} op_t;

	typedef struct packed {
		op_t        op;
		logic       fin;
		logic [1:0] code;
	} cmd_t;

	typedef struct packed {
		logic invalid;
		logic nyq_fail;
		logic big;
		logic triv;
		logic halve;
		logic n_zero;
		logic which_b;
		logic pole_bad;
		logic div_done;
	} stat_t;

endpackage

`default_nettype wire

### rtl/pcgd_div.sv
`timescale 1ns / 1ps
`default_nettype none

module pcgd_div (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [pcgd_pkg::DIV_W-1:0] dividend,
	input  wire logic [31:0]                divisor,
	output logic                            done,
	output logic [pcgd_pkg::DIV_W-1:0]      quot
);
	import pcgd_pkg::*;

	logic [31:0]       rem_q;
	logic [31:0]       den_q;
	logic [DIV_W-1:0]  q_q;
	logic [DIV_CW-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [32:0]       rem_sh;
	logic [32:0]       diff;
	logic              ge;

	// one restoring step
	always_comb begin
		rem_sh = {rem_q, q_q[DIV_W-1]};
		diff   = rem_sh - {1'b0, den_q};
		ge     = rem_sh >= {1'b0, den_q};
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CW'(DIV_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// remainder and quotient shift
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= divisor;
			q_q   <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? diff[31:0] : rem_sh[31:0];
			q_q   <= {q_q[DIV_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = q_q;

endmodule

`default_nettype wire

### rtl/pcgd_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module pcgd_datapath (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire pcgd_pkg::cmd_t       cmd,
	output pcgd_pkg::stat_t           stat,
	input  wire logic signed [31:0]   resistance,
	input  wire logic signed [31:0]   inductance,
	input  wire logic [19:0]          period_us,
	input  wire logic signed [31:0]   bandwidth,
	input  wire logic signed [31:0]   voltage_max,
	output logic [1:0]                status,
	output logic signed [31:0]        gain_p,
	output logic signed [31:0]        gain_i,
	output logic signed [31:0]        windup_limit,
	output logic [16:0]               plant_pole,
	output logic [16:0]               target_pole,
	output logic                      design_valid
);
	import pcgd_pkg::*;

	function automatic logic [31:0] sat52(input logic [DIV_W-1:0] v);
		sat52 = (|v[DIV_W-1:31]) ? SAT_MAX : v[31:0];
	endfunction

	function automatic logic [31:0] sat48(input logic [47:0] v);
		sat48 = (|v[47:31]) ? SAT_MAX : v[31:0];
	endfunction

	// request registers
	logic signed [31:0] r_q, l_q, bw_q, vm_q;
	logic [19:0]        ts_q;

	// working registers
	logic [31:0]       omega_q;
	logic [DIV_W-1:0]  rol_q, limq_q;
	logic [63:0]       acc_q;
	logic [63:0]       mul_p_q;
	logic [31:0]       arg_q;
	logic [DIV_W-1:0]  num_q;
	logic [21:0]       qest_q;
	logic [20:0]       y_q;
	logic [3:0]        n_q;
	logic [15:0]       x2_q, x3_q, t2_q, t3_q;
	logic [16:0]       e_q, alpha_q, beta_q;
	logic              which_q;
	logic [31:0]       rb_q, kp_q, ki_q;

	logic [31:0]       mul_a, mul_b;
	logic              div_start;
	logic [DIV_W-1:0]  div_num;
	logic [31:0]       div_den;
	logic              div_done;
	logic [DIV_W-1:0]  quot;
	logic [17:0]       pnum, pden;
	logic [16:0]       oma, omb;
	logic [DIV_W-1:0]  rem;
	logic              ok;

	pcgd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_num),
		.divisor  (div_den),
		.done     (div_done),
		.quot     (quot)
	);

	// pade terms, pole complements, remainder of the division by one million
	always_comb begin
		pnum = 18'(Q_ONE) + 18'(t2_q) - 18'(y_q >> 1) - 18'(t3_q);
		pden = 18'(Q_ONE) + 18'(y_q >> 1) + 18'(t2_q) + 18'(t3_q);
		oma  = Q_ONE - alpha_q;
		omb  = Q_ONE - beta_q;
		rem  = num_q - mul_p_q[DIV_W-1:0];
		ok   = cmd.code == STS_OK;
	end

	// status flags
	always_comb begin
		stat.invalid  = (r_q <= 32'sd0) || (l_q <= 32'sd0) || (ts_q == '0) ||
		                (bw_q <= 32'sd0) || (vm_q <= 32'sd0);
		stat.nyq_fail = mul_p_q >= NYQ_LIM;
		stat.big      = rol_q > limq_q;
		stat.triv     = (arg_q == '0) || (arg_q >= EXP_CUTOFF);
		stat.halve    = (y_q > Q_HALF) && (n_q <= MAX_HALVINGS);
		stat.n_zero   = n_q == '0;
		stat.which_b  = which_q;
		stat.pole_bad = (alpha_q == '0) || (alpha_q >= Q_ONE) ||
		                (beta_q == '0) || (beta_q >= Q_ONE);
		stat.div_done = div_done;
	end

	// multiplier operands and divider launch
	always_comb begin
		mul_a     = '0;
		mul_b     = '0;
		div_start = 1'b0;
		div_num   = '0;
		div_den   = '0;
		case (cmd.op)
			OP_CHK: begin
				mul_a = Q_TWO_PI;
				mul_b = bw_q;
			end
			OP_OMEGA: begin
				mul_a = bw_q;
				mul_b = 32'(ts_q);
			end
			OP_NYQ: begin
				div_start = !stat.nyq_fail;
				div_num   = DIV_W'({r_q, 16'h0000});
				div_den   = l_q;
			end
			OP_ROL: begin
				div_start = 1'b1;
				div_num   = DIV_LIM;
				div_den   = 32'(ts_q);
			end
			OP_LIMQ: begin
				mul_a = rol_q[31:0];
				mul_b = 32'(ts_q);
			end
			OP_PPLO: begin
				mul_a = 32'(rol_q[DIV_W-1:32]);
				mul_b = 32'(ts_q);
			end
			OP_RCP: begin
				mul_a = 32'(num_q[40:10]);
				mul_b = RCP_1E6;
			end
			OP_QEST: begin
				mul_a = 32'(mul_p_q[62:41]);
				mul_b = US_PER_S;
			end
			OP_PX2: begin
				mul_a = 32'(y_q);
				mul_b = 32'(y_q);
			end
			OP_PX3: begin
				mul_a = 32'(mul_p_q[31:16]);
				mul_b = 32'(y_q);
			end
			OP_PT2: begin
				mul_a = 32'(x2_q);
				mul_b = MUL_INV10;
			end
			OP_PT3: begin
				mul_a = 32'(x3_q);
				mul_b = MUL_INV120;
			end
			OP_PDIV: begin
				div_start = 1'b1;
				div_num   = DIV_W'({pnum, 16'h0000}) + DIV_W'(pden >> 1);
				div_den   = 32'(pden);
			end
			OP_SQ: begin
				mul_a = 32'(e_q);
				mul_b = 32'(e_q);
			end
			OP_EXPEND: begin
				mul_a = omega_q;
				mul_b = 32'(ts_q);
			end
			OP_POLES: begin
				mul_a = r_q;
				mul_b = 32'(omb);
			end
			OP_RB: begin
				mul_a = mul_p_q[47:16];
				mul_b = US_PER_S;
			end
			OP_KPDIV: begin
				div_start = 1'b1;
				div_num   = DIV_W'({rb_q, 16'h0000}) + DIV_W'(oma >> 1);
				div_den   = 32'(oma);
			end
			OP_KP: begin
				div_start = 1'b1;
				div_num   = acc_q[DIV_W-1:0] + DIV_W'(ts_q >> 1);
				div_den   = 32'(ts_q);
			end
			default: begin
				mul_a = '0;
			end
		endcase
	end

	// shared multiplier, registered product
	always_ff @(posedge clk) begin
		mul_p_q <= 64'(mul_a) * 64'(mul_b);
	end

	// working register updates
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				r_q     <= resistance;
				l_q     <= inductance;
				ts_q    <= period_us;
				bw_q    <= bandwidth;
				vm_q    <= voltage_max;
				which_q <= 1'b0;
			end
			OP_OMEGA:  omega_q <= sat48(mul_p_q[63:16]);
			OP_ROL:    rol_q   <= quot;
			OP_LIMQ:   limq_q  <= quot;
			OP_PPLO:   acc_q   <= mul_p_q;
			OP_PPHI: begin
				if (stat.big) begin
					arg_q <= SAT_MAX;
				end else begin
					num_q <= DIV_W'(acc_q + {mul_p_q[31:0], 32'h0} + 64'(US_HALF));
				end
			end
			OP_QEST:   qest_q <= mul_p_q[62:41];
			// quotient estimate is low by at most one; beyond 2^41 the exponential is zero
			OP_QFIX: begin
				arg_q <= (|num_q[DIV_W-1:41]) ? SAT_MAX :
				         32'(qest_q) + {31'd0, rem >= DIV_W'(US_PER_S)};
			end
			OP_EXP0: begin
				if (stat.triv) begin
					e_q <= (arg_q == '0) ? Q_ONE : '0;
				end else begin
					y_q <= 21'(arg_q);
					n_q <= '0;
				end
			end
			OP_HALVE: begin
				if (stat.halve) begin
					y_q <= y_q >> 1;
					n_q <= n_q + 1'b1;
				end
			end
			OP_PX3:    x2_q <= mul_p_q[31:16];
			OP_PT2:    x3_q <= mul_p_q[31:16];
			OP_PT3:    t2_q <= mul_p_q[31:16];
			OP_PSUM:   t3_q <= mul_p_q[31:16];
			OP_PRES:   e_q  <= quot[16:0];
			OP_SQW: begin
				e_q <= mul_p_q[32:16];
				n_q <= n_q - 1'b1;
			end
			OP_EXPEND: begin
				if (!which_q) begin
					alpha_q <= e_q;
					which_q <= 1'b1;
				end else begin
					beta_q <= e_q;
				end
			end
			OP_ARGBDIV: num_q <= DIV_W'(mul_p_q + 64'(US_HALF));
			OP_RB:     rb_q  <= mul_p_q[47:16];
			OP_KPDIV:  acc_q <= mul_p_q;
			OP_KP:     kp_q  <= sat52(quot);
			OP_KI:     ki_q  <= sat52(quot);
			default: begin
				which_q <= which_q;
			end
		endcase
	end

	// result register, zeroed on error
	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			status       <= cmd.code;
			gain_p       <= ok ? kp_q : '0;
			gain_i       <= ok ? ki_q : '0;
			windup_limit <= ok ? vm_q : '0;
			plant_pole   <= ok ? alpha_q : '0;
			target_pole  <= ok ? beta_q : '0;
			design_valid <= ok;
		end
	end

endmodule

`default_nettype wire

### rtl/pcgd_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module pcgd_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  wire logic            out_ready,
	input  wire pcgd_pkg::stat_t stat,
	output pcgd_pkg::cmd_t       cmd
);
	import pcgd_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_RUN  = 4'b0010,
		S_WAIT = 4'b0100,
		S_FIN  = 4'b1000
	} state_t;

	state_t     state_q, state_d;
	op_t        op_q, op_d;
	logic [1:0] code_q, code_d;
	logic       ov_q;
	logic       can_fin;

	// sequencer
	always_comb begin
		state_d  = state_q;
		op_d     = op_q;
		code_d   = code_q;
		cmd.op   = OP_NONE;
		cmd.fin  = 1'b0;
		cmd.code = code_q;
		can_fin  = !ov_q || out_ready;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.op  = OP_LOAD;
					op_d    = OP_CHK;
					state_d = S_RUN;
				end
			end
			S_RUN: begin
				cmd.op = op_q;
				case (op_q)
					OP_CHK: begin
						if (stat.invalid) begin
							code_d  = STS_INVALID;
							state_d = S_FIN;
						end else begin
							op_d = OP_OMEGA;
						end
					end
					OP_OMEGA: op_d = OP_NYQ;
					OP_NYQ: begin
						if (stat.nyq_fail) begin
							code_d  = STS_RANGE;
							state_d = S_FIN;
						end else begin
							op_d    = OP_ROL;
							state_d = S_WAIT;
						end
					end
					OP_ROL: begin
						op_d    = OP_LIMQ;
						state_d = S_WAIT;
					end
					OP_LIMQ: op_d = OP_PPLO;
					OP_PPLO: op_d = OP_PPHI;
					OP_PPHI: op_d = stat.big ? OP_EXP0 : OP_RCP;
					OP_RCP:  op_d = OP_QEST;
					OP_QEST: op_d = OP_QFIX;
					OP_QFIX: op_d = OP_EXP0;
					OP_EXP0: op_d = stat.triv ? OP_EXPEND : OP_HALVE;
					OP_HALVE: begin
						if (!stat.halve) begin
							op_d = OP_PX2;
						end
					end
					OP_PX2:  op_d = OP_PX3;
					OP_PX3:  op_d = OP_PT2;
					OP_PT2:  op_d = OP_PT3;
					OP_PT3:  op_d = OP_PSUM;
					OP_PSUM: op_d = OP_PDIV;
					OP_PDIV: begin
						op_d    = OP_PRES;
						state_d = S_WAIT;
					end
					OP_PRES:    op_d = OP_SQ;
					OP_SQ:      op_d = stat.n_zero ? OP_EXPEND : OP_SQW;
					OP_SQW:     op_d = OP_SQ;
					OP_EXPEND:  op_d = stat.which_b ? OP_POLES : OP_ARGBDIV;
					OP_ARGBDIV: op_d = OP_RCP;
					OP_POLES: begin
						if (stat.pole_bad) begin
							code_d  = STS_RANGE;
							state_d = S_FIN;
						end else begin
							op_d = OP_RB;
						end
					end
					OP_RB: op_d = OP_KPDIV;
					OP_KPDIV: begin
						op_d    = OP_KP;
						state_d = S_WAIT;
					end
					OP_KP: begin
						op_d    = OP_KI;
						state_d = S_WAIT;
					end
					OP_KI: begin
						code_d  = STS_OK;
						state_d = S_FIN;
					end
					default: begin
						state_d = S_IDLE;
					end
				endcase
			end
			S_WAIT: begin
				if (stat.div_done) begin
					state_d = S_RUN;
				end
			end
			S_FIN: begin
				if (can_fin) begin
					cmd.fin = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q    <= OP_NONE;
			code_q  <= STS_OK;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			op_q    <= op_d;
			code_q  <= code_d;
			if (cmd.fin) begin
				ov_q <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	assign in_ready  = state_q == S_IDLE;
	assign out_valid = ov_q;

endmodule

`default_nettype wire

### rtl/pi_current_gain_designer.sv
// PI current-loop gain designer, matched pole-zero tuning in q16.16.
// Slave stream: one transfer carries a design request (resistance,
// inductance, loop period in microseconds, bandwidth, voltage limit).
// Master stream: one transfer per request with the status, Kp, Ki, the
// windup limit and both poles; error results carry zeroed gains.
// Requests are handled one at a time. A full design runs six divisions
// on a 52-step serial restoring divider, plus up to six halvings and six
// squarings per exponential on one shared 32x32 multiplier; the two
// divisions by one million use a reciprocal multiply and one correction
// step. Invalid arguments finish right after the argument check, a
// Nyquist failure after the Nyquist check, a pole out of range after
// both exponentials.
// The result sits in an output register; a new request is taken while it
// waits, and the block holds at its finish step until the receiver takes
// the previous result, so a stalled receiver only delays completion.
// Reset clears the sequencer and the output valid; no request or result
// survives it.
`timescale 1ns / 1ps
`default_nettype none

module pi_current_gain_designer (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	// resistance[31:0], inductance[63:32], period_us[83:64],
	// bandwidth[115:84], voltage_max[147:116], zero fill[151:148]
	input  wire logic [151:0] s_axis_tdata,
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// status[1:0], gain_p[33:2], gain_i[65:34], windup_limit[97:66],
	// plant_pole[114:98], target_pole[131:115], design_valid[132],
	// zero fill[135:133]
	output logic [135:0]      m_axis_tdata
);
	import pcgd_pkg::*;

	cmd_t               cmd;
	stat_t              stat;
	logic [1:0]         status;
	logic signed [31:0] gain_p, gain_i, windup_limit;
	logic [16:0]        plant_pole, target_pole;
	logic               design_valid;

	pcgd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.stat      (stat),
		.cmd       (cmd)
	);

	pcgd_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.resistance   (s_axis_tdata[31:0]),
		.inductance   (s_axis_tdata[63:32]),
		.period_us    (s_axis_tdata[83:64]),
		.bandwidth    (s_axis_tdata[115:84]),
		.voltage_max  (s_axis_tdata[147:116]),
		.status       (status),
		.gain_p       (gain_p),
		.gain_i       (gain_i),
		.windup_limit (windup_limit),
		.plant_pole   (plant_pole),
		.target_pole  (target_pole),
		.design_valid (design_valid)
	);

	// result packing
	assign m_axis_tdata = {3'b000, design_valid, target_pole, plant_pole,
	                       windup_limit, gain_i, gain_p, status};

endmodule

`default_nettype wire
